// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and codes shared by the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int MAX_FRAME      = 64;
	localparam int FRAME_OVERHEAD = 8;
	localparam int PAYLOAD_START  = 5;
	localparam int TAIL_BYTES     = 3;
	localparam int STORE_DEPTH    = MAX_FRAME - FRAME_OVERHEAD;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int PLEN_W         = $clog2(STORE_DEPTH + 1);
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = CFG_IDX_W'(1);

	localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd85;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_HEADER = 3'd1;
	localparam logic [2:0] ERR_LENGTH    = 3'd2;
	localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_LEN,
		PH_CMDHI,
		PH_CMDLO,
		PH_PAYLOAD,
		PH_CHECK,
		PH_DONE
	} sfd_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PUT,
		ST_LAST
	} sfd_back_st_t;

	typedef struct packed {
		logic [2:0]        err;
		logic [15:0]       command;
		logic [PLEN_W-1:0] plen;
	} sfd_job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} sfd_wr_t;

	typedef struct packed {
		logic queued;
		logic busy;
	} sfd_stat_t;

endpackage

// ===== rtl/core/sfd_if.sv =====
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channel interfaces for received bytes, results and config writes.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       buffer_end;

	modport source (output valid, output rx_byte, output buffer_end, input ready);
	modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface sfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] command;
	logic [2:0]  error_code;
	logic        last_of_run;

	modport source (output valid, output kind, output payload_byte, output command,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input kind, input payload_byte, input command,
		input error_code, input last_of_run, output ready);
endinterface

interface sfd_cfg_if import sfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/serial_frame_deframer.sv =====
// results: a buffer-end byte's verdict is pushed to the job queue; for a reject or an empty
//   payload the result register loads from ST_LAST, for the first payload byte from ST_PUT after ST_READ
// throughput: one byte per cycle in unless the job queue is full; payload drains
//   through the store read port and output register, each byte read before it is put;
//   bytes in the payload phase wait while an earlier frame's results are queued or draining
// reset: arst_n asynchronous active low; payload store is not cleared
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Header/length/checksum frame parser with a two-entry job queue between
// the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
module serial_frame_deframer import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfd_cfg_if.sink   cfg,
	sfd_rx_if.sink    rx,
	sfd_res_if.source res
);

	logic      push, q_full, q_valid, q_pop;
	sfd_job_t  push_job, q_job;
	sfd_wr_t   wr;
	sfd_stat_t stat;

	sfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.rx       (rx),
		.q_full   (q_full),
		.stat     (stat),
		.push     (push),
		.push_job (push_job),
		.wr       (wr)
	);

	sfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_job   (q_job),
		.pop       (q_pop)
	);

	sfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.stat    (stat),
		.res     (res)
	);

endmodule

// ===== rtl/core/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: header hunt, length, command, payload store writes, checksum,
// and the end-of-buffer verdict pushed to the job queue.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sfd_cfg_if.sink       cfg,
	sfd_rx_if.sink        rx,
	input  logic          q_full,
	input  sfd_stat_t     stat,
	output logic          push,
	output sfd_job_t      push_job,
	output sfd_wr_t       wr
);

	sfd_phase_t  phase_q, phase_n;
	logic [7:0]  hdr1_q, hdr2_q;
	logic [7:0]  seen_q, seen_n;
	logic [7:0]  len_q, len_n;
	logic [15:0] cmd_q, cmd_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  chk_q, chk_n;
	logic [2:0]  ferr_q, ferr_n;
	logic [2:0]  err;
	logic [7:0]  off;
	logic        take;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !q_full && !(phase_q == PH_PAYLOAD && (stat.queued || stat.busy));
	assign take      = rx.valid && rx.ready;
	assign off       = seen_q - 8'(PAYLOAD_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= HEADER_FIRST_RST;
			hdr2_q <= HEADER_SECOND_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_HEADER_FIRST:  hdr1_q <= cfg.data;
				REG_HEADER_SECOND: hdr2_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			seen_q  <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
			ferr_q  <= '0;
		end else if (take) begin
			if (rx.buffer_end) begin
				phase_q <= PH_HUNT1;
				seen_q  <= '0;
				len_q   <= '0;
				cmd_q   <= '0;
				sum_q   <= '0;
				chk_q   <= '0;
				ferr_q  <= '0;
			end else begin
				phase_q <= phase_n;
				seen_q  <= seen_n;
				len_q   <= len_n;
				cmd_q   <= cmd_n;
				sum_q   <= sum_n;
				chk_q   <= chk_n;
				ferr_q  <= ferr_n;
			end
		end
	end

	always_comb begin
		phase_n = phase_q;
		seen_n  = seen_q;
		len_n   = len_q;
		cmd_n   = cmd_q;
		sum_n   = sum_q;
		chk_n   = chk_q;
		ferr_n  = ferr_q;
		wr      = '0;
		case (phase_q)
			PH_HUNT1: begin
				if (rx.rx_byte == hdr1_q) phase_n = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (rx.rx_byte == hdr2_q) begin
					if (seen_q == 8'd1) begin
						sum_n   = hdr1_q + hdr2_q;
						phase_n = PH_LEN;
					end else begin
						ferr_n  = ERR_LENGTH;
						phase_n = PH_DONE;
					end
				end else if (rx.rx_byte != hdr1_q) begin
					phase_n = PH_HUNT1;
				end
			end
			PH_LEN: begin
				len_n = rx.rx_byte;
				sum_n = sum_q + rx.rx_byte;
				if (rx.rx_byte < 8'(FRAME_OVERHEAD)) begin
					ferr_n  = ERR_LENGTH;
					phase_n = PH_DONE;
				end else if (rx.rx_byte > 8'(MAX_FRAME)) begin
					ferr_n  = ERR_TOO_LONG;
					phase_n = PH_DONE;
				end else begin
					phase_n = PH_CMDHI;
				end
			end
			PH_CMDHI: begin
				cmd_n   = {rx.rx_byte, 8'd0};
				sum_n   = sum_q + rx.rx_byte;
				phase_n = PH_CMDLO;
			end
			PH_CMDLO: begin
				cmd_n   = {cmd_q[15:8], rx.rx_byte};
				sum_n   = sum_q + rx.rx_byte;
				phase_n = (len_q == 8'(FRAME_OVERHEAD)) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				wr.en   = take && seen_q >= 8'(PAYLOAD_START) && off < 8'(STORE_DEPTH);
				wr.addr = off[ADDR_W-1:0];
				wr.data = rx.rx_byte;
				sum_n   = sum_q + rx.rx_byte;
				if ({1'b0, seen_q} + 9'(1 + TAIL_BYTES) >= {1'b0, len_q}) phase_n = PH_CHECK;
			end
			PH_CHECK: begin
				chk_n   = rx.rx_byte;
				phase_n = PH_DONE;
			end
			default: ;
		endcase
		if (seen_q == 8'd255) ferr_n = ERR_LENGTH;
		else seen_n = seen_q + 8'd1;

		if (phase_n == PH_HUNT1 || phase_n == PH_HUNT2) err = ERR_NO_HEADER;
		else if (ferr_n == ERR_LENGTH || seen_n != len_n) err = ERR_LENGTH;
		else if (ferr_n == ERR_TOO_LONG) err = ERR_TOO_LONG;
		else if (phase_n != PH_DONE) err = ERR_LENGTH;
		else if (sum_n != chk_n) err = ERR_CHECKSUM;
		else err = ERR_NONE;

		push             = take && rx.buffer_end;
		push_job.err     = err;
		push_job.command = cmd_n;
		push_job.plen    = PLEN_W'(len_n - 8'(FRAME_OVERHEAD));
	end

endmodule

// ===== rtl/core/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module sfd_queue import sfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sfd_job_t push_job,
	output logic     full,
	output logic     pop_valid,
	output sfd_job_t pop_job,
	input  logic     pop
);

	sfd_job_t   slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full      = cnt_q == 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_job   = slot_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/core/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// Result sequencer: holds the payload store, drains payload bytes of a good
// frame through the output register, then the status or reject result.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sfd_wr_t   wr,
	input  logic      q_valid,
	input  sfd_job_t  q_job,
	output logic      q_pop,
	output sfd_stat_t stat,
	sfd_res_if.source res
);

	sfd_back_st_t      st_q, st_n;
	sfd_job_t          job_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        rd_data_q;
	logic              slot_free, load_pay, load_last;
	logic              res_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        pay_q;
	logic [15:0]       cmd_q;
	logic [2:0]        err_q;
	logic              last_q;

	assign slot_free   = !res_valid_q || res.ready;
	assign stat.queued = q_valid;
	assign stat.busy   = st_q != ST_IDLE;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (st_q == ST_READ) rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_n;
	end

	always_comb begin
		st_n      = st_q;
		q_pop     = 1'b0;
		load_pay  = 1'b0;
		load_last = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_job.err != ERR_NONE || q_job.plen == '0) st_n = ST_LAST;
					else st_n = ST_READ;
				end
			end
			ST_READ: st_n = ST_PUT;
			ST_PUT: begin
				if (slot_free) begin
					load_pay = 1'b1;
					if ((PLEN_W'(idx_q) + PLEN_W'(1)) == job_q.plen) st_n = ST_LAST;
					else st_n = ST_READ;
				end
			end
			ST_LAST: begin
				if (slot_free) begin
					load_last = 1'b1;
					st_n      = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			idx_q <= '0;
		end else if (load_pay) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
		if (load_pay) begin
			kind_q <= KIND_PAYLOAD;
			pay_q  <= rd_data_q;
			cmd_q  <= job_q.command;
			err_q  <= ERR_NONE;
			last_q <= 1'b0;
		end else if (load_last) begin
			pay_q  <= 8'd0;
			last_q <= 1'b1;
			err_q  <= job_q.err;
			if (job_q.err != ERR_NONE) begin
				kind_q <= KIND_REJECT;
				cmd_q  <= 16'd0;
			end else begin
				kind_q <= KIND_ACCEPT;
				cmd_q  <= job_q.command;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (load_pay || load_last) res_valid_q <= 1'b1;
		else if (res.ready) res_valid_q <= 1'b0;
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = kind_q;
	assign res.payload_byte = pay_q;
	assign res.command      = cmd_q;
	assign res.error_code   = err_q;
	assign res.last_of_run  = last_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PUT |-> PLEN_W'(idx_q) < job_q.plen)
		else $error("payload index past frame length");

	a_no_store_write_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> st_q == ST_IDLE && !q_valid)
		else $error("payload store written while a frame drains");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && kind_q == KIND_REJECT |->
			pay_q == 8'd0 && cmd_q == 16'd0 && last_q && err_q != ERR_NONE)
		else $error("malformed reject result");
`endif

endmodule
